@@ design/pfa_pkg.sv @@
// Package for the placement fit allocator: request/response payload types,
// command, strategy and register codes, and the scan control struct.
// No dependencies.
`default_nettype none

package pfa_pkg;

   localparam int BIDX_W = 6;   // block_index / chosen_block field width
   localparam int SIZE_W = 16;  // size field width
   localparam int REM_W  = 16;  // remaining field width
   localparam int CSR_W  = 7;   // widest configuration register

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PLACE = 1'b1;

   // Placement strategies
   localparam logic [1:0] STRAT_FIRST = 2'd0;
   localparam logic [1:0] STRAT_NEXT  = 2'd1;
   localparam logic [1:0] STRAT_WORST = 2'd2;
   localparam logic [1:0] STRAT_BEST  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_STRATEGY = 1'b0;
   localparam logic CSR_BLOCKS   = 1'b1;

   typedef struct packed {
      logic              command;
      logic [BIDX_W-1:0] block_index;
      logic [SIZE_W-1:0] size;
   } req_type;

   typedef struct packed {
      logic              placed;
      logic [BIDX_W-1:0] chosen_block;
      logic [REM_W-1:0]  remaining;
   } rsp_type;

   // Control from the sequencer to the shared fit compare unit
   typedef struct packed {
      logic       clear;
      logic       step;
      logic [1:0] strategy;
   } fit_ctrl_type;

endpackage

`default_nettype wire

@@ design/pfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/pfa_fit_unit.sv @@
// Shared fit compare unit: tests one stored capacity per step against the
// request size and keeps the current pick. Depends on pfa_pkg.
`default_nettype none

module pfa_fit_unit
   import pfa_pkg::*;
#(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fit_ctrl_type         ctrl,
   input  wire logic [SIZE_BITS-1:0] rd_cap,
   input  wire logic [IDX_W-1:0]     rd_idx,
   input  wire logic [SIZE_BITS-1:0] req_size,
   output logic                      found,
   output logic      [IDX_W-1:0]     pick_idx,
   output logic      [SIZE_BITS-1:0] pick_cap
);

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_idx_ff, pick_idx_in;
   logic [SIZE_BITS-1:0] pick_cap_ff, pick_cap_in;
   logic                 fits;
   logic                 better;
   logic                 take;

   assign fits = rd_cap >= req_size;

   always_comb begin
      case (ctrl.strategy)
         STRAT_WORST: better = rd_cap > pick_cap_ff;
         STRAT_BEST:  better = rd_cap < pick_cap_ff;
         default:     better = 1'b0;
      endcase
   end

   // first hit always wins; later hits only displace it for worst/best fit
   assign take = ctrl.step && fits && (!found_ff || better);

   always_comb begin
      found_in    = found_ff;
      pick_idx_in = pick_idx_ff;
      pick_cap_in = pick_cap_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         pick_idx_in = rd_idx;
         pick_cap_in = rd_cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_idx_ff <= pick_idx_in;
      pick_cap_ff <= pick_cap_in;
   end

   assign found    = found_ff;
   assign pick_idx = pick_idx_ff;
   assign pick_cap = pick_cap_ff;

endmodule

`default_nettype wire

@@ design/placement_fit_allocator_core.sv @@
// Placement fit allocator: a capacity table in RAM plus a sequencer that
// scans it one entry per cycle through a shared fit compare unit.
// Depends on pfa_pkg, pfa_ram and pfa_fit_unit.
//
// A load command is answered in the cycle after it is accepted;
// busy never rises for it. A place command holds busy and returns its
// result after scanning up to m entries, m being the active block count
// (min of blocks_in_use and MAX_BLOCKS); first and next fit end the scan
// early, once the fit unit has registered the first fitting block. Next
// fit first reduces its start position modulo m in the ST_MOD state.
// The scan length is set by the single RAM read port, one entry per cycle.
// With m zero, a place command answers "not placed" in the next cycle.
// Each result shows on rsp_data for exactly one cycle with rsp_valid high
// and cannot be held off; a new request may be started in that same cycle.
// The capacity table is not cleared by reset: load every block in use first.
`default_nettype none

module placement_fit_allocator_core
   import pfa_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int DIV_W  = IDX_W + CNT_W;
   localparam int MCNT_W = $clog2(IDX_W + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MOD    = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           strategy_ff;
   logic [CSR_W-1:0]     blocks_ff;
   logic [IDX_W-1:0]     next_start_ff, next_start_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [MCNT_W-1:0]    mcnt_ff, mcnt_in;
   logic                 stg_valid_ff, stg_valid_in;
   logic [IDX_W-1:0]     stg_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CNT_W-1:0]     active_cnt;
   logic                 accept;
   logic [SIZE_BITS-1:0] req_size;
   logic                 in_range;
   logic [IDX_W-1:0]     rem_step;
   logic                 issue_en;
   logic                 addr_wrap;
   logic                 scan_done;
   logic [SIZE_BITS-1:0] left_cap;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] rd_data;

   fit_ctrl_type         fit_ctrl;
   logic                 fit_found;
   logic [IDX_W-1:0]     pick_idx;
   logic [SIZE_BITS-1:0] pick_cap;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= STRAT_FIRST;
         blocks_ff   <= CSR_W'(64);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STRATEGY: strategy_ff <= csr_wdata[1:0];
            CSR_BLOCKS:   blocks_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      if (32'(blocks_ff) > 32'(MAX_BLOCKS)) begin
         active_cnt = CNT_W'(MAX_BLOCKS);
      end else begin
         active_cnt = CNT_W'(blocks_ff);
      end
   end

   assign busy     = state_ff != ST_IDLE;
   assign accept   = start && !busy;
   assign req_size = SIZE_BITS'(req_data.size);
   assign in_range = 32'(req_data.block_index) < 32'(MAX_BLOCKS);

   // one restoring step of next_start mod m
   always_comb begin
      if (DIV_W'(rem_ff) >= div_ff) begin
         rem_step = rem_ff - IDX_W'(div_ff);
      end else begin
         rem_step = rem_ff;
      end
   end

   assign issue_en  = (state_ff == ST_SCAN) && (count_ff != active_cnt);
   assign addr_wrap = (CNT_W'(addr_ff) + CNT_W'(1)) == active_cnt;
   assign scan_done = (fit_found && (strategy_ff == STRAT_FIRST ||
                                     strategy_ff == STRAT_NEXT))
                      || (count_ff == active_cnt && !stg_valid_ff);
   assign left_cap  = pick_cap - size_ff;

   assign stg_valid_in = issue_en;

   always_comb begin
      state_in      = state_ff;
      next_start_in = next_start_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      mcnt_in       = mcnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_LOAD) begin
                  wr_en               = in_range;
                  wr_addr             = IDX_W'(req_data.block_index);
                  wr_data             = req_size;
                  rsp_valid_in        = 1'b1;
                  rsp_in.placed       = 1'b0;
                  rsp_in.chosen_block = req_data.block_index;
                  rsp_in.remaining    = in_range ? REM_W'(req_size) : '0;
               end else begin
                  size_in  = req_size;
                  count_in = '0;
                  if (active_cnt == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else if (strategy_ff == STRAT_NEXT) begin
                     state_in = ST_MOD;
                     rem_in   = next_start_ff;
                     div_in   = DIV_W'(active_cnt) << (IDX_W - 1);
                     mcnt_in  = MCNT_W'(IDX_W - 1);
                  end else begin
                     state_in = ST_SCAN;
                     addr_in  = '0;
                  end
               end
            end
         end
         ST_MOD: begin
            rem_in  = rem_step;
            div_in  = div_ff >> 1;
            mcnt_in = mcnt_ff - MCNT_W'(1);
            if (mcnt_ff == '0) begin
               state_in = ST_SCAN;
               addr_in  = rem_step;
            end
         end
         ST_SCAN: begin
            if (issue_en) begin
               count_in = count_ff + CNT_W'(1);
               addr_in  = addr_wrap ? '0 : addr_ff + IDX_W'(1);
            end
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (fit_found) begin
               wr_en               = 1'b1;
               wr_addr             = pick_idx;
               wr_data             = left_cap;
               rsp_in.placed       = 1'b1;
               rsp_in.chosen_block = BIDX_W'(pick_idx);
               rsp_in.remaining    = REM_W'(left_cap);
               if (strategy_ff == STRAT_NEXT) begin
                  next_start_in = (pick_idx == IDX_W'(MAX_BLOCKS - 1)) ?
                                  '0 : pick_idx + IDX_W'(1);
               end
            end else begin
               rsp_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_start_ff <= '0;
         stg_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_start_ff <= next_start_in;
         stg_valid_ff  <= stg_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      mcnt_ff    <= mcnt_in;
      stg_idx_ff <= addr_ff;
      rsp_ff     <= rsp_in;
   end

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_cap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign fit_ctrl.clear    = accept;
   assign fit_ctrl.step     = (state_ff == ST_SCAN) && stg_valid_ff;
   assign fit_ctrl.strategy = strategy_ff;

   pfa_fit_unit #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W)
   ) u_fit (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fit_ctrl),
      .rd_cap   (rd_data),
      .rd_idx   (stg_idx_ff),
      .req_size (size_ff),
      .found    (fit_found),
      .pick_idx (pick_idx),
      .pick_cap (pick_cap)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ design/pfa_checker.sv @@
// Port-level checker for placement_fit_allocator_core, bound into that module.
// Depends on pfa_pkg.
`default_nettype none

module pfa_checker
   import pfa_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire rsp_type          rsp_data
);

   // an accepted request either answers at once or starts a scan
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither answered nor started a scan");

   // results only appear once the block is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a placement is only reported after a scan
   a_placed_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.placed |-> $past(busy))
      else $error("placed result without a scan");

   // finishing a scan always produces a result
   a_scan_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("scan ended without a result");

endmodule

bind placement_fit_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire

@@ dv/pfa_fit_checker.sv @@
// Response checker for the placement fit allocator: follows the CSR writes and
// accepted requests, predicts each response and compares it field by field.
// Depends on pfa_pkg.
module pfa_fit_checker
   import pfa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               placed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;

   logic [SIZE_W-1:0] capacity [TABLE_DEPTH];
   logic [BIDX_W-1:0] next_fit_from;
   logic [1:0]        strategy;
   logic [CSR_W-1:0]  blocks_in_use;
   rsp_type           awaited_rsps [$];
   rsp_type           want;

   initial begin
      fail_count   = 0;
      pending      = 0;
      placed_count = 0;
   end

   // Apply one request to the shadow table and return the response it causes.
   function automatic rsp_type predict_fit(input req_type r);
      rsp_type res;
      int      m;
      int      pos;
      int      pick;
      int      j;
      bit      found;
      res   = '0;
      found = 1'b0;
      pick  = 0;
      if (r.command == CMD_LOAD) begin
         capacity[r.block_index] = r.size;
         res.chosen_block = r.block_index;
         res.remaining    = r.size;
         return res;
      end
      m = (int'(blocks_in_use) > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
      if (strategy == STRAT_NEXT) begin
         pos = (m > 0) ? int'(next_fit_from) % m : 0;
         for (j = 0; j < m && !found; j++) begin
            if (capacity[pos] >= r.size) begin
               found = 1'b1;
               pick  = pos;
            end else begin
               pos = (pos + 1 == m) ? 0 : pos + 1;
            end
         end
      end else begin
         // first fit keeps the lowest hit; worst/best replace only on a strict win
         for (j = 0; j < m; j++) begin
            if (capacity[j] >= r.size) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
               end else if (strategy == STRAT_WORST && capacity[j] > capacity[pick]) begin
                  pick = j;
               end else if (strategy == STRAT_BEST && capacity[j] < capacity[pick]) begin
                  pick = j;
               end
            end
         end
      end
      if (!found)
         return res;
      capacity[pick] = capacity[pick] - r.size;
      if (strategy == STRAT_NEXT)
         next_fit_from = BIDX_W'(pick + 1);
      res.placed       = 1'b1;
      res.chosen_block = BIDX_W'(pick);
      res.remaining    = capacity[pick];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (capacity[i])
            capacity[i] = '0;
         next_fit_from = '0;
         strategy      = STRAT_FIRST;
         blocks_in_use = CSR_W'(64);
         awaited_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsps.size() == 0) begin
               $error("response with no request outstanding: %p", rsp_data);
               fail_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_data.placed !== want.placed) begin
                  $error("placed: expected %0d, got %0d", want.placed, rsp_data.placed);
                  fail_count++;
               end
               if (rsp_data.chosen_block !== want.chosen_block) begin
                  $error("chosen_block: expected %0d, got %0d",
                         want.chosen_block, rsp_data.chosen_block);
                  fail_count++;
               end
               if (rsp_data.remaining !== want.remaining) begin
                  $error("remaining: expected %0d, got %0d",
                         want.remaining, rsp_data.remaining);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STRATEGY: begin
                  strategy = csr_wdata[1:0];
               end
               CSR_BLOCKS: begin
                  blocks_in_use = csr_wdata;
               end
            endcase
         end
         if (start && !busy) begin
            want = predict_fit(req_data);
            if (want.placed)
               placed_count++;
            awaited_rsps.push_back(want);
         end
      end
      pending = awaited_rsps.size();
   end

endmodule

@@ dv/tb.sv @@
// Top of the placement fit allocator testbench: clock, reset, CSR and request
// stimulus, a stall watchdog and the verdict.
// Depends on pfa_pkg, placement_fit_allocator_core and pfa_fit_checker.
module tb
   import pfa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_REQS  = 48;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_data  = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = CSR_STRATEGY;
   logic [CSR_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int placed_count;
   int idle_pct   = 19;
   int n_loads    = 0;
   int n_places   = 0;
   int stall_cnt  = 0;
   int active_blocks;

   placement_fit_allocator_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pfa_fit_checker fit_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .placed_count (placed_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cnt = 0;
      end else begin
         stall_cnt++;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no request or response for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Hold start until the request is taken at a rising edge with busy low.
   task automatic send_req(input logic cmd, input logic [BIDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] size);
      req_type r;
      r.command     = cmd;
      r.block_index = idx;
      r.size        = size;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (cmd == CMD_LOAD)
         n_loads++;
      else
         n_places++;
   endtask

   // Drop start and hold off until every response is back and the block is idle.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy)
         @(negedge clock);
   endtask

   task automatic set_config(input logic [1:0] strat, input int blocks);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STRATEGY;
      csr_wdata <= CSR_W'(strat);
      @(negedge clock);
      csr_index <= CSR_BLOCKS;
      csr_wdata <= CSR_W'(blocks);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      active_blocks = (blocks > 64) ? 64 : blocks;
   endtask

   function automatic logic [SIZE_W-1:0] rand_capacity();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return SIZE_W'($urandom_range(0, 65535));
         default: return SIZE_W'($urandom_range(0, 20000));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] rand_request_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SIZE_W'($urandom_range(0, 65535));
         default: return SIZE_W'($urandom_range(1, 3000));
      endcase
   endfunction

   initial begin
      logic [1:0]        strat;
      int                blocks;
      logic [BIDX_W-1:0] idx;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: small table, every strategy, zero and full-scale sizes.
      set_config(STRAT_FIRST, 4);
      send_req(CMD_LOAD, 6'd0, 16'd0);
      send_req(CMD_LOAD, 6'd1, 16'hFFFF);
      send_req(CMD_LOAD, 6'd2, 16'd100);
      send_req(CMD_LOAD, 6'd3, 16'd100);
      send_req(CMD_LOAD, 6'd63, 16'h5555);
      send_req(CMD_PLACE, 6'd63, 16'hFFFF);
      send_req(CMD_PLACE, 6'd0, 16'd0);
      send_req(CMD_PLACE, 6'd0, 16'hFFFF);
      send_req(CMD_PLACE, 6'd0, 16'd50);
      drain();
      set_config(STRAT_WORST, 4);
      send_req(CMD_PLACE, 6'd0, 16'd10);
      send_req(CMD_LOAD, 6'd2, 16'd90);
      send_req(CMD_PLACE, 6'd0, 16'd5);
      drain();
      set_config(STRAT_BEST, 4);
      send_req(CMD_PLACE, 6'd0, 16'd40);
      send_req(CMD_PLACE, 6'd0, 16'd0);
      drain();
      set_config(STRAT_NEXT, 4);
      repeat (3) send_req(CMD_PLACE, 6'd0, 16'd1);
      send_req(CMD_PLACE, 6'd0, 16'hFFFF);
      drain();
      // shrink the count so the stored next-fit start wraps modulo three
      set_config(STRAT_NEXT, 3);
      send_req(CMD_PLACE, 6'd0, 16'd1);
      drain();
      set_config(STRAT_FIRST, 0);
      send_req(CMD_PLACE, 6'd0, 16'd1);

      // Fill the whole table so any block count can be searched.
      for (int i = 0; i < 64; i++)
         send_req(CMD_LOAD, BIDX_W'(i), rand_capacity());

      for (int p = 0; p < PHASES; p++) begin
         drain();
         strat = p[1:0];
         case (p)
            0:       blocks = 64;
            1:       blocks = 1;
            2:       blocks = 127;
            3:       blocks = 64;
            4:       blocks = 0;
            default: blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127)
                                                          : $urandom_range(1, 64);
         endcase
         set_config(strat, blocks);
         idle_pct = (p == 5) ? 0 : 19;
         for (int k = 0; k < PHASE_REQS; k++) begin
            if ($urandom_range(0, 99) < 35) begin
               // bias refills toward blocks that are actually searched
               if ($urandom_range(0, 1) == 1 && active_blocks > 0)
                  idx = BIDX_W'($urandom_range(0, active_blocks - 1));
               else
                  idx = BIDX_W'($urandom_range(0, 63));
               send_req(CMD_LOAD, idx, rand_capacity());
            end else begin
               send_req(CMD_PLACE, BIDX_W'($urandom_range(0, 63)), rand_request_size());
            end
            if ($urandom_range(0, 99) < 3)
               drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      $display("Covered %0d requests: %0d capacity loads and %0d placements, %0d placed",
               n_loads + n_places, n_loads, n_places, placed_count);
      $display("All four fit strategies ran with block counts 0, 1, 64, 127 and random");
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
design/pfa_pkg.sv
design/pfa_ram.sv
design/pfa_fit_unit.sv
design/placement_fit_allocator_core.sv
design/pfa_checker.sv
dv/pfa_fit_checker.sv
dv/tb.sv
